@@ rtl/core/contrast_stretch_grey_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the contrast stretch back end
// ----------------------------------------------------------------------------
`ifndef CONTRAST_STRETCH_GREY_ASSERT_SVH
`define CONTRAST_STRETCH_GREY_ASSERT_SVH

// same-cycle implication
`define CSG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/csg_pkg.sv @@
// ----------------------------------------------------------------------------
// csg_pkg
// Types and constants of the grey-level contrast stretch block.
// ----------------------------------------------------------------------------
package csg_pkg;

   localparam int FRAC_REG_W   = 17;
   localparam int GAIN_BITS    = 16;
   localparam int GAIN_MAG_W   = 31;
   localparam int CMD_DEPTH    = 4;
   localparam int RSP_DEPTH    = 4;

   localparam logic [7:0]            FULL_SCALE   = 8'd255;
   localparam logic [FRAC_REG_W-1:0] ONE_Q16      = 17'h1_0000;
   localparam logic [FRAC_REG_W-1:0] BLACK_RESET  = 17'h0_0000;
   localparam logic [GAIN_MAG_W-1:0] GAIN_ONE     = 31'h0001_0000;
   localparam logic [GAIN_MAG_W-1:0] GAIN_MAG_MAX = 31'h7FFF_FFFF;

   typedef enum logic [0:0] {
      CSR_BLACK_FRACTION = 1'b0,
      CSR_WHITE_FRACTION = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      OP_MEASURE = 1'b0,
      OP_APPLY   = 1'b1
   } op_type;

   typedef struct packed {
      logic       op;
      logic [7:0] pixel;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel_out;
      logic       last_out;
   } rsp_type;

   // classified request handed from front to back
   typedef struct packed {
      logic       apply;
      logic [7:0] pixel;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic round_up;
   } div_status_type;

endpackage

@@ rtl/core/csg_queue.sv @@
// ----------------------------------------------------------------------------
// csg_queue
// Small synchronous FIFO with registered slots and full/empty flags.
// ----------------------------------------------------------------------------
module csg_queue #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/csg_front.sv @@
// ----------------------------------------------------------------------------
// csg_front
// Request intake: classifies each request and queues it for the back end.
// ----------------------------------------------------------------------------
module csg_front
   import csg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    cmd_valid,
   output cmd_type cmd_data,
   input  logic    cmd_pop
);

   cmd_type cmd_in;
   logic    cmd_empty;

   always_comb begin
      cmd_in.apply = (op_type'(req_data.op) == OP_APPLY);
      cmd_in.pixel = req_data.pixel;
      cmd_in.last  = req_data.last;
   end

   csg_queue #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cmd_in),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_data),
      .empty     (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;

endmodule

@@ rtl/core/csg_gain_div.sv @@
// ----------------------------------------------------------------------------
// csg_gain_div
// Restoring divider, one quotient bit per cycle: 255 << (F+16) / divisor,
// with a half-to-even round-up flag from the final remainder.
// ----------------------------------------------------------------------------
module csg_gain_div
   import csg_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [FRACTION_BITS+7:0]    divisor,
   output div_status_type              status,
   output logic [FRACTION_BITS+23:0]   quotient
);

   localparam int LVL_W = FRACTION_BITS + 8;
   localparam int NUM_W = FRACTION_BITS + 8 + GAIN_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);
   localparam logic [NUM_W-1:0] NUMERATOR = {FULL_SCALE, {(FRACTION_BITS + GAIN_BITS){1'b0}}};

   logic             busy_ff, busy_in;
   logic             fin_ff, fin_in;
   logic             done_ff, done_in;
   logic             round_ff, round_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LVL_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [LVL_W-1:0] dvs_ff, dvs_in;
   logic [LVL_W:0]   trial, diff, rem_twice;
   logic             fits;

   always_comb begin
      trial     = {rem_ff, num_ff[NUM_W-1]};
      fits      = (trial >= {1'b0, dvs_ff});
      diff      = trial - {1'b0, dvs_ff};
      rem_twice = {rem_ff, 1'b0};

      busy_in  = busy_ff;
      fin_in   = 1'b0;
      done_in  = 1'b0;
      round_in = round_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      num_in   = num_ff;
      dvs_in   = dvs_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         quo_in  = '0;
         num_in  = NUMERATOR;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[LVL_W-1:0] : trial[LVL_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         // round half to even on the quotient
         round_in = (rem_twice > {1'b0, dvs_ff}) ||
                    ((rem_twice == {1'b0, dvs_ff}) && quo_ff[0]);
         done_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      round_ff <= round_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      num_ff   <= num_in;
      dvs_ff   <= dvs_in;
   end

   assign status.done     = done_ff;
   assign status.round_up = round_ff;
   assign quotient        = quo_ff;

endmodule

@@ rtl/core/csg_back.sv @@
// ----------------------------------------------------------------------------
// csg_back
// Execution side: min/max tracking, level and gain latch, the apply
// pipeline and the response queue.
// ----------------------------------------------------------------------------
`include "contrast_stretch_grey_assert.svh"

module csg_back
   import csg_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  cmd_type               cmd_data,
   output logic                  cmd_pop,
   input  logic [FRAC_REG_W-1:0] black_fraction,
   input  logic [FRAC_REG_W-1:0] white_fraction,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data
);

   localparam int LVL_W  = FRACTION_BITS + 8;
   localparam int NUM_W  = FRACTION_BITS + 8 + GAIN_BITS;
   localparam int PROD_W = LVL_W + GAIN_MAG_W;
   localparam int SH     = FRACTION_BITS + GAIN_BITS;
   localparam int RES_W  = PROD_W - SH;
   localparam int CRD_W  = $clog2(RSP_DEPTH + 1);
   localparam int SCL_W  = 25 + FRACTION_BITS;
   localparam logic [LVL_W-1:0] WHITE_RESET = {FULL_SCALE, {FRACTION_BITS{1'b0}}};

   typedef enum logic [3:0] {
      ST_RUN    = 4'b0001,
      ST_LEVEL  = 4'b0010,
      ST_START  = 4'b0100,
      ST_DIVIDE = 4'b1000
   } back_state_type;

   // lo + span * frac in 8.F, product rounded half to even to F fraction bits
   function automatic logic [LVL_W-1:0] level_of(input logic [7:0] lo,
                                                 input logic [7:0] span,
                                                 input logic [FRAC_REG_W-1:0] frac);
      logic [FRAC_REG_W-1:0] f;
      logic [24:0]           prod;
      logic [SCL_W-1:0]      scaled;
      logic [LVL_W:0]        q;
      logic                  up;
      logic [LVL_W:0]        sum;
      f      = (frac > ONE_Q16) ? ONE_Q16 : frac;
      prod   = 25'(span) * 25'(f);
      scaled = {prod, {FRACTION_BITS{1'b0}}};
      q      = scaled[SCL_W-1:16];
      up     = scaled[15] && ((scaled[14:0] != '0) || q[0]);
      sum    = {1'b0, lo, {FRACTION_BITS{1'b0}}} + q + (LVL_W + 1)'(up);
      return sum[LVL_W-1:0];
   endfunction

   back_state_type        state_ff, state_in;
   logic [7:0]            min_ff, min_in, max_ff, max_in;
   logic [7:0]            lo_ff, lo_in, span_ff, span_in;
   logic [LVL_W-1:0]      black_ff, black_in, white_ff, white_in;
   logic [GAIN_MAG_W-1:0] gain_mag_ff, gain_mag_in;
   logic                  gain_neg_ff, gain_neg_in;
   logic [CRD_W-1:0]      credit_ff, credit_in;

   logic [7:0]            new_min, new_max;
   logic                  issue_apply, rsp_taken, rsp_full;
   logic                  div_start;
   logic [LVL_W-1:0]      div_divisor;
   div_status_type        div_status;
   logic [NUM_W-1:0]      div_quotient;
   logic [NUM_W:0]        quo_rounded;

   // apply pipeline
   logic                  a1_valid_ff, a2_valid_ff, a3_valid_ff;
   logic [7:0]            a1_pixel_ff;
   logic                  a1_last_ff, a2_last_ff, a3_last_ff;
   logic [LVL_W-1:0]      p_fixed, a2_dmag_ff, a2_dmag_in;
   logic                  a2_dneg_ff, a2_dneg_in, a3_dneg_ff;
   logic                  a2_eq_ff, a2_eq_in, a3_eq_ff;
   logic                  a2_le_ff, a2_le_in, a3_le_ff;
   logic [PROD_W-1:0]     a3_prod_ff, a3_prod_in;
   logic                  res_up;
   logic [RES_W:0]        res;
   rsp_type               rsp_in;

   // ---------------- control ----------------
   assign new_min     = (cmd_data.pixel < min_ff) ? cmd_data.pixel : min_ff;
   assign new_max     = (cmd_data.pixel > max_ff) ? cmd_data.pixel : max_ff;
   assign cmd_pop     = (state_ff == ST_RUN) && cmd_valid &&
                        (!cmd_data.apply || (credit_ff != '0));
   assign issue_apply = cmd_pop && cmd_data.apply;
   assign rsp_taken   = rsp_pop && !rsp_empty;
   assign div_divisor = (white_ff < black_ff) ? black_ff - white_ff : white_ff - black_ff;
   assign quo_rounded = {1'b0, div_quotient} + (NUM_W + 1)'(div_status.round_up);

   always_comb begin
      state_in    = state_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      lo_in       = lo_ff;
      span_in     = span_ff;
      black_in    = black_ff;
      white_in    = white_ff;
      gain_mag_in = gain_mag_ff;
      gain_neg_in = gain_neg_ff;
      div_start   = 1'b0;
      credit_in   = credit_ff - CRD_W'(issue_apply) + CRD_W'(rsp_taken);

      unique case (state_ff)
         ST_RUN: begin
            if (cmd_pop && !cmd_data.apply) begin
               min_in = new_min;
               max_in = new_max;
               if (cmd_data.last) begin
                  lo_in    = new_min;
                  span_in  = (new_max >= new_min) ? new_max - new_min : 8'd0;
                  min_in   = FULL_SCALE;
                  max_in   = 8'd0;
                  state_in = ST_LEVEL;
               end
            end
         end
         ST_LEVEL: begin
            black_in = level_of(lo_ff, span_ff, black_fraction);
            white_in = level_of(lo_ff, span_ff, white_fraction);
            state_in = ST_START;
         end
         ST_START: begin
            if (white_ff == black_ff) begin
               gain_mag_in = GAIN_MAG_MAX;
               gain_neg_in = 1'b0;
               state_in    = ST_RUN;
            end else begin
               gain_neg_in = (white_ff < black_ff);
               div_start   = 1'b1;
               state_in    = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               gain_mag_in = (quo_rounded > {{(NUM_W + 1 - GAIN_MAG_W){1'b0}}, GAIN_MAG_MAX}) ?
                             GAIN_MAG_MAX : quo_rounded[GAIN_MAG_W-1:0];
               state_in    = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_RUN;
         min_ff      <= FULL_SCALE;
         max_ff      <= 8'd0;
         black_ff    <= '0;
         white_ff    <= WHITE_RESET;
         gain_mag_ff <= GAIN_ONE;
         gain_neg_ff <= 1'b0;
         credit_ff   <= CRD_W'(RSP_DEPTH);
      end else begin
         state_ff    <= state_in;
         min_ff      <= min_in;
         max_ff      <= max_in;
         black_ff    <= black_in;
         white_ff    <= white_in;
         gain_mag_ff <= gain_mag_in;
         gain_neg_ff <= gain_neg_in;
         credit_ff   <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      span_ff <= span_in;
   end

   csg_gain_div #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_gain_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // ---------------- apply pipeline ----------------
   always_comb begin
      p_fixed    = {a1_pixel_ff, {FRACTION_BITS{1'b0}}};
      a2_dneg_in = (p_fixed < black_ff);
      a2_dmag_in = a2_dneg_in ? black_ff - p_fixed : p_fixed - black_ff;
      a2_eq_in   = (white_ff == black_ff);
      a2_le_in   = (p_fixed <= black_ff);
      a3_prod_in = PROD_W'(a2_dmag_ff) * PROD_W'(gain_mag_ff);
   end

   always_comb begin
      res_up = a3_prod_ff[SH-1] && ((a3_prod_ff[SH-2:0] != '0) || a3_prod_ff[SH]);
      res    = {1'b0, a3_prod_ff[PROD_W-1:SH]} + (RES_W + 1)'(res_up);
      rsp_in.last_out = a3_last_ff;
      if (a3_eq_ff) begin
         rsp_in.pixel_out = a3_le_ff ? 8'd0 : FULL_SCALE;
      end else if (a3_dneg_ff != gain_neg_ff) begin
         rsp_in.pixel_out = 8'd0;
      end else if (res > (RES_W + 1)'(FULL_SCALE)) begin
         rsp_in.pixel_out = FULL_SCALE;
      end else begin
         rsp_in.pixel_out = res[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_valid_ff <= 1'b0;
         a2_valid_ff <= 1'b0;
         a3_valid_ff <= 1'b0;
      end else begin
         a1_valid_ff <= issue_apply;
         a2_valid_ff <= a1_valid_ff;
         a3_valid_ff <= a2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a1_pixel_ff <= cmd_data.pixel;
      a1_last_ff  <= cmd_data.last;
      a2_last_ff  <= a1_last_ff;
      a2_dmag_ff  <= a2_dmag_in;
      a2_dneg_ff  <= a2_dneg_in;
      a2_eq_ff    <= a2_eq_in;
      a2_le_ff    <= a2_le_in;
      a3_last_ff  <= a2_last_ff;
      a3_prod_ff  <= a3_prod_in;
      a3_dneg_ff  <= a2_dneg_ff;
      a3_eq_ff    <= a2_eq_ff;
      a3_le_ff    <= a2_le_ff;
   end

   csg_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (a3_valid_ff),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

   // ---------------- checks ----------------
   `CSG_ASSERT_NOW(a_rsp_no_overflow, clock, reset, a3_valid_ff, !rsp_full, "response queue overrun")
   `CSG_ASSERT_NOW(a_pop_only_in_run, clock, reset, cmd_pop, state_ff == ST_RUN, "pop outside run")
   `CSG_ASSERT_NOW(a_div_done_in_divide, clock, reset, div_status.done, state_ff == ST_DIVIDE, "stray divide done")
   `CSG_ASSERT_NEXT(a_last_measure_latch, clock, reset, cmd_pop && !cmd_data.apply && cmd_data.last, state_ff == ST_LEVEL, "level latch missed")

endmodule

@@ rtl/core/contrast_stretch_grey.sv @@
// ----------------------------------------------------------------------------
// contrast_stretch_grey
// Min/max grey-level autocontrast over a frame sent twice: a measure pass
// collects the pixel range, an apply pass stretches each pixel.
// ----------------------------------------------------------------------------
//
//   channel   ports                               direction  moves
//   request   req_push req_full req_data          in         op, pixel, last
//   response  rsp_empty rsp_pop rsp_data          out        pixel_out, last_out
//   csr       csr_write csr_index csr_data        in         black/white fraction
//
// In its run state the back end pops requests back to back; apply requests need response queue room.
// A measure request flagged last holds the back end while it latches the
// levels and, unless the two levels are equal, runs the bit-serial gain
// divider (FRACTION_BITS + 24 quotient bits) plus rounding.
// An apply request passes the command queue, the apply registers a1, a2 and
// a3 and the response queue before its response is on the response ports.
// Reset is synchronous; there is no clearing pass.
// Either side may stall; the request queue keeps taking requests while the
// back end is busy, until it fills.
//
module contrast_stretch_grey
   import csg_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_data,
   // response channel
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   // register write port
   input  logic                  csr_write,
   input  csr_index_type         csr_index,
   input  logic [FRAC_REG_W-1:0] csr_data
);

   // fraction registers; to be written only while the block is idle, which the block itself does not enforce
   logic [FRAC_REG_W-1:0] black_frac_ff, black_frac_in;
   logic [FRAC_REG_W-1:0] white_frac_ff, white_frac_in;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_data;

   always_comb begin
      black_frac_in = black_frac_ff;
      white_frac_in = white_frac_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_BLACK_FRACTION: black_frac_in = csr_data;
            CSR_WHITE_FRACTION: white_frac_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         black_frac_ff <= BLACK_RESET;
         white_frac_ff <= ONE_Q16;
      end else begin
         black_frac_ff <= black_frac_in;
         white_frac_ff <= white_frac_in;
      end
   end

   // front: classify and queue requests
   csg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   // back: statistics, level/gain latch, stretch pipeline, response queue
   csg_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd_data       (cmd_data),
      .cmd_pop        (cmd_pop),
      .black_fraction (black_frac_ff),
      .white_fraction (white_frac_ff),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_data       (rsp_data)
   );

endmodule
